// ----- src/fqmc_pkg.sv -----
// shared types and constants for the fifo queue with match count
// no dependencies; imported by fqmc_cell, fifo_queue_with_match_count and the bench
package fqmc_pkg;

  // default configuration
  localparam int unsigned DefDepth     = 16;
  localparam int unsigned DefValueBits = 32;

  // fixed field widths of the item ports
  localparam int unsigned ActionBits = 2;
  localparam int unsigned DataBits   = 32;
  localparam int unsigned StatusBits = 2;
  localparam int unsigned CountBits  = 5;

  // front value reported while the queue is empty (-9999)
  localparam logic [DataBits-1:0] EmptyFront = 32'hFFFF_D8F1;

  typedef enum logic [ActionBits-1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_DRAIN = 2'd2
  } action_e;

  typedef enum logic [StatusBits-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_DRAIN = 1'b1
  } state_e;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic push;   // the first free cell takes the incoming value
    logic shift;  // every cell takes its right neighbor's contents
  } cell_ctrl_t;

endpackage

// ----- src/fqmc_cell.sv -----
// one storage cell of the queue chain: a value and an occupied flag
// depends on fqmc_pkg for the command struct
module fqmc_cell #(
  parameter int unsigned W = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fqmc_pkg::cell_ctrl_t ctrl_i,
  input  logic [W-1:0]        data_i,
  input  logic                prev_occ_i,
  input  logic [W-1:0]        next_val_i,
  input  logic                next_occ_i,
  output logic [W-1:0]        val_o,
  output logic                occ_o
);
  import fqmc_pkg::*;

  logic [W-1:0] val_q, val_d;
  logic         occ_q, occ_d;
  logic         take_push;

  // the first free cell is the one whose left neighbor is occupied
  assign take_push = ctrl_i.push && !occ_q && prev_occ_i;

  always_comb begin
    val_d = val_q;
    occ_d = occ_q;
    if (ctrl_i.shift) begin
      val_d = next_val_i;
      occ_d = next_occ_i;
    end else if (take_push) begin
      val_d = data_i;
      occ_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  assign occ_o = occ_q;

endmodule

// ----- src/fifo_queue_with_match_count.sv -----
// top level of the fifo queue with match count: control and the cell chain
// depends on fqmc_pkg and fqmc_cell
module fifo_queue_with_match_count #(
  parameter int unsigned DEPTH      = fqmc_pkg::DefDepth,
  parameter int unsigned VALUE_BITS = fqmc_pkg::DefValueBits
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [fqmc_pkg::ActionBits-1:0]      action_i,
  input  logic signed [fqmc_pkg::DataBits-1:0] data_value_i,
  output logic                                 result_valid_o,
  output logic [fqmc_pkg::StatusBits-1:0]      status_o,
  output logic signed [fqmc_pkg::DataBits-1:0] front_value_o,
  output logic                                 is_empty_o,
  output logic [fqmc_pkg::CountBits-1:0]       occupancy_o,
  output logic [fqmc_pkg::CountBits-1:0]       match_count_o
);
  // A bounded first-in first-out queue of DEPTH entries, held in a row of
  // cells with the front entry always in cell 0. An item is taken when start
  // is high and busy is low. Each item gives exactly one result, shown for a
  // single cycle while result_valid_o is high; the receiver cannot stall, so
  // it must sample the result in that cycle. For push, pop and the unused
  // action code the result appears in the cycle after the item is taken and
  // busy stays low, so a new item may be taken every cycle. A count-and-drain
  // shifts the chain one entry per cycle past the compare at cell 0 and holds
  // busy, taking no new item, until the chain is empty; its result appears
  // as busy falls. Values are stored and compared in their low
  // min(VALUE_BITS, 32) bits and reported zero-extended; occupancy and
  // match count wrap modulo 32.
  import fqmc_pkg::*;

  localparam int unsigned StoreBits = (VALUE_BITS < DataBits) ? VALUE_BITS : DataBits;
  localparam int unsigned CntW      = $clog2(DEPTH + 1);

  // cell chain
  logic [StoreBits-1:0] cell_val [DEPTH];
  logic [DEPTH-1:0]     cell_occ;
  cell_ctrl_t           ctrl;
  logic [StoreBits-1:0] push_data;

  // control registers
  state_e               state_q, state_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [StatusBits-1:0] status_q, status_d;
  logic [CountBits-1:0] match_q, match_d;
  logic [StoreBits-1:0] key_q, key_d;
  logic                 strobe_q, strobe_d;

  logic                 accept;
  logic [DataBits-1:0]  front_ext;
  logic [CntW+CountBits-1:0] count_ext;

  assign push_data = data_value_i[StoreBits-1:0];
  assign busy      = (state_q == ST_DRAIN);
  assign accept    = start && !busy;

  // row of cells; cell 0 is the queue front, each shifts toward it on a pop or a drain step
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 prev_occ;
    logic [StoreBits-1:0] next_val;
    logic                 next_occ;

    if (i == 0) begin : g_first
      assign prev_occ = 1'b1;
    end else begin : g_mid
      assign prev_occ = cell_occ[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_val = '0;
      assign next_occ = 1'b0;
    end else begin : g_inner
      assign next_val = cell_val[i+1];
      assign next_occ = cell_occ[i+1];
    end

    fqmc_cell #(
      .W (StoreBits)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .data_i     (push_data),
      .prev_occ_i (prev_occ),
      .next_val_i (next_val),
      .next_occ_i (next_occ),
      .val_o      (cell_val[i]),
      .occ_o      (cell_occ[i])
    );
  end

  // next state and chain commands
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    status_d   = status_q;
    match_d    = match_q;
    key_d      = key_q;
    strobe_d   = 1'b0;
    ctrl.push  = 1'b0;
    ctrl.shift = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          status_d = STAT_OK;
          match_d  = '0;
          unique case (action_i)
            ACT_PUSH: begin
              strobe_d = 1'b1;
              if (count_q == CntW'(DEPTH)) begin
                // full: value dropped, state kept
                status_d = STAT_FULL;
              end else begin
                ctrl.push = 1'b1;
                count_d   = count_q + 1'b1;
              end
            end
            ACT_POP: begin
              strobe_d = 1'b1;
              if (count_q == '0) begin
                status_d = STAT_EMPTY;
              end else begin
                ctrl.shift = 1'b1;
                count_d    = count_q - 1'b1;
              end
            end
            ACT_DRAIN: begin
              // result goes out once the chain has emptied
              state_d = ST_DRAIN;
              key_d   = push_data;
            end
            default: begin
              // unused code: report the queue as it stands
              strobe_d = 1'b1;
            end
          endcase
        end
      end
      ST_DRAIN: begin
        if (count_q != '0) begin
          ctrl.shift = 1'b1;
          count_d    = count_q - 1'b1;
          if (cell_val[0] == key_q) begin
            match_d = match_q + 1'b1;
          end
        end else begin
          state_d  = ST_IDLE;
          strobe_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      strobe_q <= 1'b0;
      status_q <= STAT_OK;
      match_q  <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      strobe_q <= strobe_d;
      status_q <= status_d;
      match_q  <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  // result fields; the queue is stable during the strobe cycle
  assign front_ext = DataBits'(cell_val[0]);
  assign count_ext = {{CountBits{1'b0}}, count_q};

  assign result_valid_o = strobe_q;
  assign status_o       = status_q;
  assign is_empty_o     = (count_q == '0);
  assign front_value_o  = (count_q == '0) ? EmptyFront : front_ext;
  assign occupancy_o    = count_ext[CountBits-1:0];
  assign match_count_o  = match_q;

endmodule

// ----- verif/tb.sv -----
// self-checking bench for fifo_queue_with_match_count: directed script, then random traffic
// imports fqmc_pkg; needs only the rtl under src, reads no files
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fqmc_pkg::*;

  localparam int HalfPeriod = 6;
  localparam int Depth = DefDepth;
  // action code the block leaves undecoded, it must report the queue unchanged
  localparam logic [ActionBits-1:0] ActUnused = 2'd3;
  // cycles with no handshake before the run is declared hung
  localparam int StallLimit = 2000;
  // a drain walks every slot, so allow about two sweeps for stray results
  localparam int SettleCycles = 2 * Depth + 8;
  localparam int RandomSegments = 8;
  localparam int SegmentItems = 144;

  // one result item as the block reports it
  typedef struct packed {
    logic [StatusBits-1:0] status;
    logic [DataBits-1:0]   front;
    logic                  empty;
    logic [CountBits-1:0]  occupancy;
    logic [CountBits-1:0]  match_cnt;
  } report_t;

  // one line of the directed script
  typedef struct {
    logic [ActionBits-1:0] act;
    logic [DataBits-1:0]   value;
    int                    reps;
    bit                    pinned;
    report_t               want;
  } script_row_t;

  // dut ports, every input known from time zero
  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [ActionBits-1:0] action_i = '0;
  logic signed [DataBits-1:0] data_value_i = '0;
  logic                  result_valid_o;
  logic [StatusBits-1:0] status_o;
  logic signed [DataBits-1:0] front_value_o;
  logic                  is_empty_o;
  logic [CountBits-1:0]  occupancy_o;
  logic [CountBits-1:0]  match_count_o;

  // hand-typed expectation riding along with the item being offered
  bit      pin_flag = 1'b0;
  report_t pin_want = '0;

  // shadow queue kept by the predictor
  logic [DataBits-1:0] model_ring [Depth];
  int model_head = 0;
  int model_tail = 0;
  int model_count = 0;

  // reports still owed by the dut, oldest first
  report_t expected_reports [$];
  script_row_t script [$];

  int errors = 0;
  int stall_cycles = 0;
  int items_taken = 0;
  int results_seen = 0;
  int full_rejects = 0;
  int empty_pops = 0;
  int drains_with_hits = 0;
  int peak_matches = 0;

  fifo_queue_with_match_count dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .data_value_i   (data_value_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .front_value_o  (front_value_o),
    .is_empty_o     (is_empty_o),
    .occupancy_o    (occupancy_o),
    .match_count_o  (match_count_o)
  );

  always begin
    #(HalfPeriod) clk_i = 1'b1;
    #(HalfPeriod) clk_i = 1'b0;
  end

  // apply one action to the shadow queue and return the report it should produce
  function automatic report_t predict_report(input logic [ActionBits-1:0] act,
                                             input logic [DataBits-1:0] value);
    report_t rep;
    int hits;
    hits = 0;
    rep.status = STAT_OK;
    case (act)
      ACT_PUSH: begin
        if (model_count >= Depth) begin
          // full: value dropped, nothing moves
          rep.status = STAT_FULL;
        end else begin
          model_ring[model_tail] = value;
          model_tail = (model_tail + 1) % Depth;
          model_count++;
        end
      end
      ACT_POP: begin
        if (model_count == 0) begin
          rep.status = STAT_EMPTY;
        end else begin
          model_head = (model_head + 1) % Depth;
          model_count--;
        end
      end
      ACT_DRAIN: begin
        // walk from the front, counting equal entries, until nothing is left
        while (model_count > 0) begin
          if (model_ring[model_head] == value) hits++;
          model_head = (model_head + 1) % Depth;
          model_count--;
        end
      end
      default: begin
        // unused code: state untouched, report the queue as it stands
      end
    endcase
    rep.front = (model_count == 0) ? EmptyFront : model_ring[model_head];
    rep.empty = (model_count == 0);
    rep.occupancy = CountBits'(model_count);
    rep.match_cnt = CountBits'(hits);
    return rep;
  endfunction

  task automatic compare_field(input string field, input logic [DataBits-1:0] want,
                               input logic [DataBits-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    end
  endtask

  // accept side and result side seen at the same edge: prediction first, so a
  // result that could leave in the cycle of its own item still finds its match
  always @(posedge clk_i) begin : scoreboard
    report_t predicted;
    report_t want;
    bit moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (start && !busy) begin
        predicted = predict_report(action_i, data_value_i);
        expected_reports.push_back(pin_flag ? pin_want : predicted);
        items_taken++;
        moved = 1'b1;
        if (predicted.status == STAT_FULL) full_rejects++;
        if (predicted.status == STAT_EMPTY) empty_pops++;
        if (predicted.match_cnt != 0) drains_with_hits++;
        if (int'(predicted.match_cnt) > peak_matches) peak_matches = predicted.match_cnt;
      end
      if (result_valid_o) begin
        results_seen++;
        moved = 1'b1;
        if (expected_reports.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, status %0h front %0h",
                   $time, status_o, front_value_o);
        end else begin
          want = expected_reports.pop_front();
          compare_field("status", DataBits'(want.status), DataBits'(status_o));
          compare_field("front_value", want.front, front_value_o);
          compare_field("is_empty", DataBits'(want.empty), DataBits'(is_empty_o));
          compare_field("occupancy", DataBits'(want.occupancy), DataBits'(occupancy_o));
          compare_field("match_count", DataBits'(want.match_cnt), DataBits'(match_count_o));
        end
      end
    end
    stall_cycles = moved ? 0 : stall_cycles + 1;
  end

  task automatic script_row(input logic [ActionBits-1:0] act, input logic [DataBits-1:0] value,
                            input int reps);
    script_row_t row;
    row.act = act;
    row.value = value;
    row.reps = reps;
    row.pinned = 1'b0;
    row.want = '0;
    script.push_back(row);
  endtask

  task automatic script_pinned(input logic [ActionBits-1:0] act, input logic [DataBits-1:0] value,
                               input logic [StatusBits-1:0] status,
                               input logic [DataBits-1:0] front, input logic empty,
                               input logic [CountBits-1:0] occupancy,
                               input logic [CountBits-1:0] match_cnt);
    script_row_t row;
    row.act = act;
    row.value = value;
    row.reps = 1;
    row.pinned = 1'b1;
    row.want = '{status, front, empty, occupancy, match_cnt};
    script.push_back(row);
  endtask

  // offer one item, optionally after an idle gap, and hold it until taken
  task automatic offer_item(input logic [ActionBits-1:0] act, input logic [DataBits-1:0] value,
                            input bit pinned, input report_t want, input int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk_i);
    end
    start <= 1'b1;
    action_i <= act;
    data_value_i <= value;
    pin_flag <= pinned;
    pin_want <= want;
    // busy is sampled as it stood at the edge, so this is the accepting edge
    @(posedge clk_i iff !busy);
  endtask

  // values from a short pool repeat often enough to make drains find matches
  function automatic logic [DataBits-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return EmptyFront;
      3, 4, 5: return DataBits'($urandom_range(3));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ActionBits-1:0] pick_action(input int push_pct);
    int roll;
    roll = $urandom_range(99);
    if (roll < push_pct) return ACT_PUSH;
    if (roll < push_pct + 6) return ACT_DRAIN;
    if (roll < push_pct + 9) return ActUnused;
    return ACT_POP;
  endfunction

  task automatic run_stimulus();
    int idle_pct [4] = '{0, 58, 0, 20};
    int push_pct;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty corners, extreme values, a sentinel-valued entry at the
    // front while not empty, fill to full, rejected push, unused code, full drain
    script_pinned(ACT_POP, 32'h0, STAT_EMPTY, EmptyFront, 1'b1, 5'd0, 5'd0);
    script_pinned(ACT_DRAIN, 32'd5, STAT_OK, EmptyFront, 1'b1, 5'd0, 5'd0);
    script_pinned(ACT_PUSH, 32'h7FFF_FFFF, STAT_OK, 32'h7FFF_FFFF, 1'b0, 5'd1, 5'd0);
    script_pinned(ACT_PUSH, 32'h8000_0000, STAT_OK, 32'h7FFF_FFFF, 1'b0, 5'd2, 5'd0);
    script_pinned(ACT_PUSH, EmptyFront, STAT_OK, 32'h7FFF_FFFF, 1'b0, 5'd3, 5'd0);
    script_pinned(ACT_POP, 32'h0, STAT_OK, 32'h8000_0000, 1'b0, 5'd2, 5'd0);
    script_pinned(ACT_POP, 32'hFFFF_FFFF, STAT_OK, EmptyFront, 1'b0, 5'd1, 5'd0);
    script_row(ACT_PUSH, 32'd5, 13);
    script_row(ACT_PUSH, 32'h0, 1);
    script_row(ACT_PUSH, 32'hFFFF_FFFF, 1);
    script_pinned(ACT_PUSH, 32'd7, STAT_FULL, EmptyFront, 1'b0, 5'd16, 5'd0);
    script_pinned(ActUnused, 32'd5, STAT_OK, EmptyFront, 1'b0, 5'd16, 5'd0);
    script_pinned(ACT_DRAIN, 32'd5, STAT_OK, EmptyFront, 1'b1, 5'd0, 5'd13);

    foreach (script[i]) begin
      repeat (script[i].reps) begin
        offer_item(script[i].act, script[i].value, script[i].pinned, script[i].want, 25);
      end
    end

    // random: segments alternate fill-heavy and pop-heavy traffic under each idle mix
    for (int seg = 0; seg < RandomSegments; seg++) begin
      push_pct = ((seg + seg / 4) % 2 == 0) ? 70 : 35;
      for (int n = 0; n < SegmentItems; n++) begin
        offer_item(pick_action(push_pct), pick_value(), 1'b0, '0, idle_pct[seg % 4]);
      end
    end
    start <= 1'b0;

    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    fork
      run_stimulus();
      wait (stall_cycles >= StallLimit);
    join_any
    if (stall_cycles >= StallLimit) begin
      errors++;
      $display("%0t: no handshake for %0d cycles, %0d reports outstanding",
               $time, StallLimit, expected_reports.size());
    end
    $display("summary: %0d items taken, %0d results checked, %0d errors",
             items_taken, results_seen, errors);
    $display("summary: %0d full rejects, %0d empty pops, %0d drains with matches (peak %0d)",
             full_rejects, empty_pops, drains_with_hits, peak_matches);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/fqmc_pkg.sv
src/fqmc_cell.sv
src/fifo_queue_with_match_count.sv
verif/tb.sv
